### hw/rtl/utf8_to_ucs2_decoder_macros.svh
// Assertion macros for the UTF-8 decoder.
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define U8U2_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8u2 check failed");
`define U8U2_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8u2 check failed");
`else
`define U8U2_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define U8U2_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/u8u2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8u2_pkg;

	localparam int MAX_RESULTS = 3;

	localparam logic [15:0] REPL_RESET = 16'h003F;
	localparam logic [15:0] MIN_TWO    = 16'h0080;
	localparam logic [15:0] MIN_THREE  = 16'h0800;
	localparam logic [15:0] SURR_LO    = 16'hD800;
	localparam logic [15:0] SURR_HI    = 16'hDFFF;

	localparam logic [1:0] CONT_TAG = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;

	typedef struct packed {
		logic [1:0]  need;
		logic [15:0] part;
		logic [1:0]  len;
		logic        after_nul;
	} state_t;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]                    num;
		result_t [MAX_RESULTS-1:0]     res;
	} batch_t;

	typedef struct packed {
		logic free;
		logic busy;
	} buf_status_t;

endpackage

`default_nettype wire

### hw/rtl/utf8_to_ucs2_decoder.sv
// UTF-8 byte stream to 16-bit code unit decoder.
// Input channel: data_byte/final_byte with in_valid, held off by in_stall.
// A byte is taken when in_valid is high and in_stall low.
// Output channel: code_unit/end_mark with out_valid; the receiver drives
// out_stall. end_mark flags the zero terminator closing each string.
// Config channel: replacement_code written on cfg_valid && cfg_ready;
// cfg_ready is always high. Write only while the block is idle.
// A taken byte is held in the input register, then decoded into the result
// register. Throughput: one byte per cycle while out_stall is low and each
// byte yields at most one result. Output is one result per cycle, so a byte
// yielding more stalls the input while results drain, one entry per cycle.
// While out_stall is high the current result holds and in_stall rises once
// the input register is full and the result register is still occupied.
// Reset clears the decode state and queue, and sets replacement_code to '?'.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_ucs2_decoder_macros.svh"

module utf8_to_ucs2_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             end_mark,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] replacement_code
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  fin_s1;
	logic [15:0]           repl_q;
	u8u2_pkg::state_t      st_q;
	u8u2_pkg::state_t      st_nxt;
	u8u2_pkg::batch_t      batch;
	u8u2_pkg::buf_status_t buf_st;
	logic                  xfer;
	logic                  accept;

	assign cfg_ready = 1'b1;
	assign xfer      = valid_s1 && buf_st.free;
	assign in_stall  = valid_s1 && !buf_st.free;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= u8u2_pkg::REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= replacement_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			fin_s1  <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (xfer) begin
			st_q <= st_nxt;
		end
	end

	u8u2_step u_step (
		.data_byte  (byte_s1),
		.final_byte (fin_s1),
		.repl       (repl_q),
		.st         (st_q),
		.nxt        (st_nxt),
		.batch      (batch)
	);

	u8u2_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (xfer),
		.batch     (batch),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.code_unit (code_unit),
		.end_mark  (end_mark),
		.status    (buf_st)
	);

	`U8U2_ASSERT_IMP(a_nul_idle, clk, arst_n, st_q.after_nul, st_q.need == 2'd0)
	`U8U2_ASSERT_IMP(a_len_ok, clk, arst_n, st_q.need != 2'd0, st_q.len == 2'd2 || st_q.len == 2'd3)
	`U8U2_ASSERT_IMP(a_need3, clk, arst_n, st_q.need == 2'd2, st_q.len == 2'd3)
	`U8U2_ASSERT_NXT(a_fin_clr, clk, arst_n, xfer && fin_s1, st_q == '0)
	`U8U2_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, valid_s1 && buf_st.busy)

endmodule

`default_nettype wire

### hw/rtl/u8u2_step.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u2_step (
	input  wire logic [7:0]      data_byte,
	input  wire logic            final_byte,
	input  wire logic [15:0]     repl,
	input  wire u8u2_pkg::state_t st,
	output u8u2_pkg::state_t     nxt,
	output u8u2_pkg::batch_t     batch
);

	logic        cont;
	logic        closed;
	logic        bad;
	logic [15:0] value;

	assign cont  = (data_byte[7:6] == u8u2_pkg::CONT_TAG);
	assign value = {st.part[9:0], data_byte[5:0]};

	always_comb begin
		if (st.len == 2'd2) begin
			bad = (value < u8u2_pkg::MIN_TWO);
		end else begin
			bad = (value < u8u2_pkg::MIN_THREE) ||
				(value inside {[u8u2_pkg::SURR_LO:u8u2_pkg::SURR_HI]});
		end
	end

	always_comb begin
		nxt       = st;
		batch     = '0;
		closed    = 1'b0;
		if (st.after_nul) begin
			if (final_byte) begin
				nxt = '0;
			end
		end else begin
			if ((st.need != 2'd0) && cont) begin
				nxt.part = value;
				nxt.need = st.need - 2'd1;
				if (st.need == 2'd1) begin
					batch.res[batch.num] = '{code: (bad ? repl : value), last: 1'b0};
					batch.num = batch.num + 2'd1;
					nxt.part = '0;
					nxt.len  = '0;
				end
			end else begin
				if (st.need != 2'd0) begin
					batch.res[batch.num] = '{code: repl, last: 1'b0};
					batch.num = batch.num + 2'd1;
					nxt.need = '0;
					nxt.part = '0;
					nxt.len  = '0;
				end
				if (data_byte == 8'h00) begin
					batch.res[batch.num] = '{code: 16'h0000, last: 1'b1};
					batch.num = batch.num + 2'd1;
					nxt = '0;
					nxt.after_nul = ~final_byte;
					closed = 1'b1;
				end else if (cont) begin
					nxt.need = '0;
				end else if (!data_byte[7]) begin
					batch.res[batch.num] = '{code: {8'h00, data_byte}, last: 1'b0};
					batch.num = batch.num + 2'd1;
				end else if (data_byte[7:5] == u8u2_pkg::LEAD2_TAG) begin
					nxt.need = 2'd1;
					nxt.len  = 2'd2;
					nxt.part = {11'd0, data_byte[4:0]};
				end else if (data_byte[7:4] == u8u2_pkg::LEAD3_TAG) begin
					nxt.need = 2'd2;
					nxt.len  = 2'd3;
					nxt.part = {12'd0, data_byte[3:0]};
				end else begin
					batch.res[batch.num] = '{code: repl, last: 1'b0};
					batch.num = batch.num + 2'd1;
				end
			end
			if (final_byte && !closed) begin
				if (nxt.need != 2'd0) begin
					batch.res[batch.num] = '{code: repl, last: 1'b0};
					batch.num = batch.num + 2'd1;
				end
				batch.res[batch.num] = '{code: 16'h0000, last: 1'b1};
				batch.num = batch.num + 2'd1;
				nxt = '0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/u8u2_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u2_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire u8u2_pkg::batch_t    batch,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic [15:0]              code_unit,
	output logic                     end_mark,
	output u8u2_pkg::buf_status_t    status
);

	u8u2_pkg::result_t res_q [u8u2_pkg::MAX_RESULTS];
	logic [1:0]        num_q;
	logic [1:0]        pos_q;
	logic              take;

	assign out_valid   = (pos_q != num_q);
	assign take        = out_valid && !out_stall;
	assign code_unit   = res_q[pos_q].code;
	assign end_mark    = res_q[pos_q].last;
	assign status.free = !out_valid || (take && ((pos_q + 2'd1) == num_q));
	assign status.busy = out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			pos_q <= '0;
		end else if (load) begin
			num_q <= batch.num;
			pos_q <= '0;
		end else if (take) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < u8u2_pkg::MAX_RESULTS; i++) begin
				res_q[i] <= batch.res[i];
			end
		end
	end

endmodule

`default_nettype wire
